FILE: sv/bts_pkg.sv
// Shared types, codes and arithmetic for the bilinear texture sampler.
package bts_pkg;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_TEX_WIDTH  = 1'b0,
    CFG_TEX_HEIGHT = 1'b1
  } cfg_addr_e;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SAMPLE,
    KIND_GREY
  } kind_e;

  localparam int unsigned CfgBits = 9;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic [15:0]        write_index;
    logic [15:0]        write_red;
    logic [15:0]        write_green;
    logic [15:0]        write_blue;
  } bts_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } bts_out_t;

  // queue entry between front and back
  typedef struct packed {
    kind_e       kind;
    logic [15:0] fu;
    logic [15:0] fv;
    logic [15:0] widx;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } bts_entry_t;

  // (a*(65536-t) + b*t) >> 16, written as a + floor((b-a)*t / 65536)
  function automatic logic [15:0] bts_lerp(logic [15:0] a, logic [15:0] b, logic [15:0] t);
    logic signed [17:0] d;
    logic signed [34:0] p;
    logic signed [17:0] s;
    d = $signed({2'b00, b}) - $signed({2'b00, a});
    p = d * $signed({1'b0, t});
    s = $signed({2'b00, a}) + 18'(p >>> 16);
    return s[15:0];
  endfunction

endpackage

FILE: sv/bts_front.sv
// Front end: classifies accepted items, queues all but out-of-range writes.
module bts_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bts_pkg::bts_in_t    in_item_i,
  input  logic                tex_empty_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output bts_pkg::bts_entry_t q_item_o
);
  import bts_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW = $clog2(QDepth);

  bts_entry_t          q_mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       cnt_q;
  bts_entry_t          entry;
  logic                push, pop, drop;

  assign in_ready_o = (cnt_q < (PtrW + 1)'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = q_mem_q[rd_ptr_q];

  always_comb begin
    entry.fu    = in_item_i.u_coord[15:0];
    entry.fv    = in_item_i.v_coord[15:0];
    entry.widx  = in_item_i.write_index;
    entry.red   = in_item_i.write_red;
    entry.green = in_item_i.write_green;
    entry.blue  = in_item_i.write_blue;
    drop        = 1'b0;
    if (in_item_i.operation == OP_WRITE) begin
      entry.kind = KIND_WRITE;
      drop = (32'(in_item_i.write_index) >= Depth);
    end else if (tex_empty_i) begin
      entry.kind = KIND_GREY;
    end else begin
      entry.kind = KIND_SAMPLE;
    end
  end

  assign push = in_valid_i && in_ready_o && !drop;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= entry;
  end

endmodule

FILE: sv/bts_back.sv
// Back end: index math, duplicated texel store and the lerp pipeline.
module bts_back #(
  parameter int unsigned MAX_WIDTH    = 256,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  output logic                                q_ready_o,
  input  bts_pkg::bts_entry_t                 q_item_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      tex_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     tex_h_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bts_pkg::bts_out_t                   out_item_o
);
  import bts_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned TW = 3 * CB;
  localparam int unsigned PW = WW + HW;
  localparam logic [15:0] Grey = 16'(((1 << CB) - 1) / 5);

  logic adv;
  logic out_vld_q;

  // stage 1: scale fractions
  logic          s1_vld_q;
  kind_e         s1_kind_q;
  logic [WW-1:0] s1_x0_q;
  logic [HW-1:0] s1_y0_q;
  logic [15:0]   s1_tx_q, s1_ty_q, s1_widx_q;
  logic [TW-1:0] s1_wdata_q;
  logic [16+WW-1:0] pu;
  logic [16+HW-1:0] pv;

  assign pu = (16 + WW)'(q_item_i.fu) * (16 + WW)'(tex_w_i - 1'b1);
  assign pv = (16 + HW)'(q_item_i.fv) * (16 + HW)'(tex_h_i - 1'b1);

  // stage 2: neighbors and row offsets
  logic          s2_vld_q;
  kind_e         s2_kind_q;
  logic [WW-1:0] s2_x0_q, s2_x1_q;
  logic [AW-1:0] s2_row0_q, s2_row1_q;
  logic [15:0]   s2_tx_q, s2_ty_q, s2_widx_q;
  logic [TW-1:0] s2_wdata_q;
  logic [WW:0]   x0p;
  logic [HW:0]   y0p;
  logic [WW-1:0] x1;
  logic [HW-1:0] y1;
  logic [PW-1:0] row0, row1;

  always_comb begin
    x0p  = {1'b0, s1_x0_q} + 1'b1;
    y0p  = {1'b0, s1_y0_q} + 1'b1;
    x1   = (x0p >= {1'b0, tex_w_i}) ? '0 : x0p[WW-1:0];
    y1   = (y0p >= {1'b0, tex_h_i}) ? '0 : y0p[HW-1:0];
    row0 = PW'(s1_y0_q) * PW'(tex_w_i);
    row1 = PW'(y1) * PW'(tex_w_i);
  end

  // stage 3: store addresses
  logic          s3_vld_q;
  kind_e         s3_kind_q;
  logic [AW-1:0] s3_a00_q, s3_a10_q, s3_a01_q, s3_a11_q;
  logic [15:0]   s3_tx_q, s3_ty_q;
  logic [TW-1:0] s3_wdata_q;

  // stage 4: texel read, two copies with two read ports each
  logic [TW-1:0] mem_top [Depth];
  logic [TW-1:0] mem_bot [Depth];
  logic          s4_vld_q;
  kind_e         s4_kind_q;
  logic [TW-1:0] s4_t00_q, s4_t10_q, s4_t01_q, s4_t11_q;
  logic [15:0]   s4_tx_q, s4_ty_q;

  // stage 5: horizontal lerps
  logic          s5_vld_q;
  kind_e         s5_kind_q;
  logic [15:0]   s5_ty_q;
  logic [15:0]   s5_top_q [3];
  logic [15:0]   s5_bot_q [3];

  bts_out_t out_q;

  assign adv         = !out_vld_q || out_ready_i;
  assign q_ready_o   = adv;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= q_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q && (s5_kind_q != KIND_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q  <= q_item_i.kind;
      s1_x0_q    <= pu[16 +: WW];
      s1_tx_q    <= pu[15:0];
      s1_y0_q    <= pv[16 +: HW];
      s1_ty_q    <= pv[15:0];
      s1_widx_q  <= q_item_i.widx;
      s1_wdata_q <= {q_item_i.blue[CB-1:0], q_item_i.green[CB-1:0], q_item_i.red[CB-1:0]};

      s2_kind_q  <= s1_kind_q;
      s2_x0_q    <= s1_x0_q;
      s2_x1_q    <= x1;
      s2_row0_q  <= AW'(row0);
      s2_row1_q  <= AW'(row1);
      s2_tx_q    <= s1_tx_q;
      s2_ty_q    <= s1_ty_q;
      s2_widx_q  <= s1_widx_q;
      s2_wdata_q <= s1_wdata_q;

      s3_kind_q  <= s2_kind_q;
      // a write carries its target address in the first slot
      s3_a00_q   <= (s2_kind_q == KIND_WRITE) ? AW'(s2_widx_q) : s2_row0_q + AW'(s2_x0_q);
      s3_a10_q   <= s2_row0_q + AW'(s2_x1_q);
      s3_a01_q   <= s2_row1_q + AW'(s2_x0_q);
      s3_a11_q   <= s2_row1_q + AW'(s2_x1_q);
      s3_tx_q    <= s2_tx_q;
      s3_ty_q    <= s2_ty_q;
      s3_wdata_q <= s2_wdata_q;

      s4_kind_q  <= s3_kind_q;
      s4_tx_q    <= s3_tx_q;
      s4_ty_q    <= s3_ty_q;

      s5_kind_q  <= s4_kind_q;
      s5_ty_q    <= s4_ty_q;
      for (int c = 0; c < 3; c++) begin
        s5_top_q[c] <= bts_lerp(16'(s4_t00_q[c*CB +: CB]), 16'(s4_t10_q[c*CB +: CB]), s4_tx_q);
        s5_bot_q[c] <= bts_lerp(16'(s4_t01_q[c*CB +: CB]), 16'(s4_t11_q[c*CB +: CB]), s4_tx_q);
      end

      if (s5_kind_q == KIND_GREY) begin
        out_q.red_out   <= Grey;
        out_q.green_out <= Grey;
        out_q.blue_out  <= Grey;
      end else begin
        out_q.red_out   <= bts_lerp(s5_top_q[0], s5_bot_q[0], s5_ty_q);
        out_q.green_out <= bts_lerp(s5_top_q[1], s5_bot_q[1], s5_ty_q);
        out_q.blue_out  <= bts_lerp(s5_top_q[2], s5_bot_q[2], s5_ty_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s3_vld_q && s3_kind_q == KIND_WRITE) mem_top[s3_a00_q] <= s3_wdata_q;
      s4_t00_q <= mem_top[s3_a00_q];
      s4_t10_q <= mem_top[s3_a10_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s3_vld_q && s3_kind_q == KIND_WRITE) mem_bot[s3_a00_q] <= s3_wdata_q;
      s4_t01_q <= mem_bot[s3_a01_q];
      s4_t11_q <= mem_bot[s3_a11_q];
    end
  end

endmodule

FILE: sv/bilinear_texture_sampler_top.sv
// Throughput: one item per cycle; the six-stage back pipeline advances whenever the
// output register is empty or taken, and a 4-entry queue decouples the input side.
// Write items give no result and update the texel store in the fourth back stage.
// Reset (rst_ni, async low) clears handshake state and both size registers; the
// texel store is not cleared, so no clearing pass is needed.
module bilinear_texture_sampler_top #(
  parameter int unsigned MAX_WIDTH    = 256,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bts_pkg::bts_in_t            in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bts_pkg::bts_out_t           out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  bts_pkg::cfg_addr_e          cfg_index_i,
  input  logic [bts_pkg::CfgBits-1:0] cfg_data_i
);
  import bts_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [CfgBits-1:0] tex_width_q, tex_height_q;
  logic [WW-1:0]      tex_w;
  logic [HW-1:0]      tex_h;
  logic               q_valid, q_ready;
  bts_entry_t         q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= '0;
      tex_height_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEX_WIDTH:  tex_width_q  <= cfg_data_i;
        CFG_TEX_HEIGHT: tex_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tex_w = (32'(tex_width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(tex_width_q);
  assign tex_h = (32'(tex_height_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(tex_height_q);

  bts_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .tex_empty_i((tex_w == '0) || (tex_h == '0)),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  bts_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_item_i   (q_item),
    .tex_w_i    (tex_w),
    .tex_h_i    (tex_h),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

FILE: sv/bts_checker.sv
// Port-level checks for the sampler, bound to the top level.
module bts_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input bts_pkg::bts_out_t out_item_o,
  input logic              cfg_ready_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  // the queue only fills through accepted items
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(in_valid_i && in_ready_o) || $past(!in_ready_o))
    else $error("input stalled without a prior accept");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid_o) && !$isunknown(in_ready_o))
    else $error("handshake output unknown");

endmodule

bind bilinear_texture_sampler_top bts_checker u_bts_checker (.*);
